>>> rtl/core/stp_pkg.sv
// Shared types, constants and helper functions for the sandpile topple engine.
// Used by the channel interfaces and the top level.
package stp_pkg;

    localparam int STP_MAX_ROWS  = 64;
    localparam int STP_MAX_COLS  = 64;
    localparam int STP_CELL_BITS = 32;

    localparam int COORD_BITS = 6;
    localparam int DATA_BITS  = 32;
    localparam int SIZE_BITS  = 7;
    localparam int LAT_BITS   = 2;
    localparam int MIN_SIZE   = 3;
    localparam int CELL_RESET = 3;

    localparam int TOTAL_BITS   = DATA_BITS + 1;
    localparam int DIV_DIGITS   = 4;
    localparam int DIV_ITERS    = (TOTAL_BITS + DIV_DIGITS - 1) / DIV_DIGITS;
    localparam int DIV_BITS     = DIV_ITERS * DIV_DIGITS;
    localparam int DIV_CNT_BITS = $clog2(DIV_ITERS);
    localparam int REM_BITS     = 3;

    localparam int APB_ADDR_BITS = 5;
    localparam int APB_DATA_BITS = 32;
    localparam int REG_IDX_BITS  = APB_ADDR_BITS - 2;

    localparam logic [REG_IDX_BITS-1:0] REG_LATTICE   = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_ROWS      = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_COLS      = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_WRAP_ROWS = 3'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_WRAP_COLS = 3'd4;

    localparam logic [LAT_BITS-1:0] LAT_SQUARE   = 2'd0;
    localparam logic [LAT_BITS-1:0] LAT_TRIANGLE = 2'd1;
    localparam logic [LAT_BITS-1:0] LAT_HEXAGON  = 2'd2;

    localparam logic [REM_BITS-1:0] DSR_SQUARE   = 3'd4;
    localparam logic [REM_BITS-1:0] DSR_TRIANGLE = 3'd6;
    localparam logic [REM_BITS-1:0] DSR_HEXAGON  = 3'd3;

    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_TOPPLE = 1'b1;

    localparam int NUM_SLOTS = 12;
    localparam int SLOT_BITS = 4;

    localparam logic [SLOT_BITS-1:0] SLOT_UP       = 4'd0;
    localparam logic [SLOT_BITS-1:0] SLOT_DOWN     = 4'd1;
    localparam logic [SLOT_BITS-1:0] SLOT_LEFT     = 4'd2;
    localparam logic [SLOT_BITS-1:0] SLOT_RIGHT    = 4'd3;
    localparam logic [SLOT_BITS-1:0] SLOT_UP_LEFT  = 4'd4;
    localparam logic [SLOT_BITS-1:0] SLOT_UP_RIGHT = 4'd5;
    localparam logic [SLOT_BITS-1:0] SLOT_DN_LEFT  = 4'd6;
    localparam logic [SLOT_BITS-1:0] SLOT_DN_RIGHT = 4'd7;
    localparam logic [SLOT_BITS-1:0] SLOT_LEFT2    = 4'd8;
    localparam logic [SLOT_BITS-1:0] SLOT_RIGHT2   = 4'd9;
    localparam logic [SLOT_BITS-1:0] SLOT_WRAP_ROW = 4'd10;
    localparam logic [SLOT_BITS-1:0] SLOT_WRAP_COL = 4'd11;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_TGT   = 6'b000100,
        S_DIV   = 6'b001000,
        S_GIVE  = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    function automatic logic [REM_BITS-1:0] divisor_of(input logic [LAT_BITS-1:0] lat);
        case (lat)
            LAT_TRIANGLE: divisor_of = DSR_TRIANGLE;
            LAT_HEXAGON:  divisor_of = DSR_HEXAGON;
            default:      divisor_of = DSR_SQUARE;
        endcase
    endfunction

    // one restoring step: returns {quotient bit, new remainder}
    function automatic logic [REM_BITS:0] div_step(
        input logic [REM_BITS-1:0] rem,
        input logic                din,
        input logic [REM_BITS-1:0] dsr
    );
        logic [REM_BITS:0] t;
        logic [REM_BITS:0] d;
        t = {rem, din};
        d = {1'b0, dsr};
        if (t >= d) begin
            t = t - d;
            div_step = {1'b1, t[REM_BITS-1:0]};
        end else begin
            div_step = {1'b0, t[REM_BITS-1:0]};
        end
    endfunction

endpackage

>>> rtl/core/stp_req_if.sv
// Request channel: valid/ready handshake carrying one command word.
// Depends on stp_pkg for field widths.
interface stp_req_if import stp_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic                  op;
    logic [COORD_BITS-1:0] row;
    logic [COORD_BITS-1:0] col;
    logic [DATA_BITS-1:0]  grains;

    modport source (output valid, output op, output row, output col, output grains,
                    input ready);
    modport sink   (input valid, input op, input row, input col, input grains,
                    output ready);
endinterface

>>> rtl/core/stp_rsp_if.sv
// Response channel: valid/ready handshake carrying one result word.
// Depends on stp_pkg for field widths.
interface stp_rsp_if import stp_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [DATA_BITS-1:0] cell_value;
    logic [DATA_BITS-1:0] share;
    logic                 applied;

    modport source (output valid, output cell_value, output share, output applied,
                    input ready);
    modport sink   (input valid, input cell_value, input share, input applied,
                    output ready);
endinterface

>>> rtl/core/stp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module stp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/core/sandpile_topple_engine_core.sv
// Sandpile topple engine top level: grid RAM, sequencer, shared divider and
// saturating adder, APB register bank. Depends on stp_pkg, stp_req_if,
// stp_rsp_if and stp_ram.
// An add reads and writes the target cell; a topple runs the radix-16 divider
// and then one grid RAM read and write per neighbour, for n neighbours
// (square up to 4, triangle up to 6, hexagon 3).
// One word in flight; the next is taken once the result moves to the output.
// Reset: a clearing pass writes 3 into all 2^(clog2(MAX_ROWS)+clog2(MAX_COLS))
// entries (4096 by default), one per cycle, before the first word.
module sandpile_topple_engine_core import stp_pkg::*; #(
    parameter int MAX_ROWS  = STP_MAX_ROWS,
    parameter int MAX_COLS  = STP_MAX_COLS,
    parameter int CELL_BITS = STP_CELL_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    stp_req_if.sink                  i_req,
    stp_rsp_if.source                o_rsp,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready
);
    localparam int RB    = $clog2(MAX_ROWS);
    localparam int CB    = $clog2(MAX_COLS);
    localparam int AW    = RB + CB;
    localparam int DEPTH = 1 << AW;
    localparam int RSW   = ($clog2(MAX_ROWS + 1) > SIZE_BITS) ? $clog2(MAX_ROWS + 1) : SIZE_BITS;
    localparam int CSW   = ($clog2(MAX_COLS + 1) > SIZE_BITS) ? $clog2(MAX_COLS + 1) : SIZE_BITS;

    localparam logic [RSW-1:0] R_MAX = RSW'(MAX_ROWS);
    localparam logic [CSW-1:0] C_MAX = CSW'(MAX_COLS);
    localparam logic [RSW-1:0] R_MIN = RSW'(MIN_SIZE);
    localparam logic [CSW-1:0] C_MIN = CSW'(MIN_SIZE);
    localparam logic [CELL_BITS-1:0] CELL_MAX = {CELL_BITS{1'b1}};

    // configuration registers
    logic [LAT_BITS-1:0]  r_lattice;
    logic [SIZE_BITS-1:0] r_rows;
    logic [SIZE_BITS-1:0] r_cols;
    logic                 r_wrap_rows;
    logic                 r_wrap_cols;
    logic                 cfg_we;
    logic [REG_IDX_BITS-1:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_idx = paddr[APB_ADDR_BITS-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lattice   <= LAT_SQUARE;
            r_rows      <= SIZE_BITS'(64);
            r_cols      <= SIZE_BITS'(64);
            r_wrap_rows <= 1'b0;
            r_wrap_cols <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                REG_LATTICE:   r_lattice   <= pwdata[LAT_BITS-1:0];
                REG_ROWS:      r_rows      <= pwdata[SIZE_BITS-1:0];
                REG_COLS:      r_cols      <= pwdata[SIZE_BITS-1:0];
                REG_WRAP_ROWS: r_wrap_rows <= pwdata[0];
                REG_WRAP_COLS: r_wrap_cols <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_LATTICE:   prdata = APB_DATA_BITS'(r_lattice);
            REG_ROWS:      prdata = APB_DATA_BITS'(r_rows);
            REG_COLS:      prdata = APB_DATA_BITS'(r_cols);
            REG_WRAP_ROWS: prdata = APB_DATA_BITS'(r_wrap_rows);
            REG_WRAP_COLS: prdata = APB_DATA_BITS'(r_wrap_cols);
            default:       prdata = '0;
        endcase
    end

    // clamped grid size
    logic [RSW-1:0] rows_ext;
    logic [CSW-1:0] cols_ext;
    logic [RSW-1:0] size_r;
    logic [CSW-1:0] size_c;

    assign rows_ext = RSW'(r_rows);
    assign cols_ext = CSW'(r_cols);
    assign size_r   = (rows_ext < R_MIN) ? R_MIN : ((rows_ext > R_MAX) ? R_MAX : rows_ext);
    assign size_c   = (cols_ext < C_MIN) ? C_MIN : ((cols_ext > C_MAX) ? C_MAX : cols_ext);

    // sequencer registers
    t_state                  r_state;
    logic [AW-1:0]           r_clr_addr;
    logic                    r_op;
    logic [COORD_BITS-1:0]   r_row;
    logic [COORD_BITS-1:0]   r_col;
    logic [DATA_BITS-1:0]    r_addend;
    logic [DIV_BITS-1:0]     r_dvd;
    logic [REM_BITS-1:0]     r_rem;
    logic [REM_BITS-1:0]     r_dsr;
    logic [DIV_CNT_BITS-1:0] r_cnt;
    logic [NUM_SLOTS-1:0]    r_mask;
    logic                    r_pend;
    logic [AW-1:0]           r_paddr;
    logic [DATA_BITS-1:0]    r_res_cell;
    logic [DATA_BITS-1:0]    r_res_share;
    logic                    r_res_applied;
    logic                    r_ovalid;
    logic [DATA_BITS-1:0]    r_ocell;
    logic [DATA_BITS-1:0]    r_oshare;
    logic                    r_oapplied;

    // input decode
    logic           req_fire;
    logic [RSW-1:0] in_rr;
    logic [CSW-1:0] in_cc;
    logic           in_range;
    logic [AW-1:0]  in_addr;

    assign i_req.ready = (r_state == S_IDLE);
    assign req_fire    = i_req.valid && i_req.ready;
    assign in_rr       = RSW'(i_req.row);
    assign in_cc       = CSW'(i_req.col);
    assign in_range    = (in_rr < size_r) && (in_cc < size_c);
    assign in_addr     = {in_rr[RB-1:0], in_cc[CB-1:0]};

    // target geometry
    logic [RSW-1:0] rr;
    logic [CSW-1:0] cc;
    logic [AW-1:0]  tgt_addr;
    logic           top, bot, lef, rig, corner, interior, hex_a, hex_b, topple_ok;
    logic [NUM_SLOTS-1:0] topple_mask;

    assign rr       = RSW'(r_row);
    assign cc       = CSW'(r_col);
    assign tgt_addr = {rr[RB-1:0], cc[CB-1:0]};
    assign top      = (rr == '0);
    assign bot      = (rr == size_r - RSW'(1));
    assign lef      = (cc == '0);
    assign rig      = (cc == size_c - CSW'(1));
    assign corner   = (top || bot) && (lef || rig);
    assign interior = (rr >= RSW'(1)) && (rr + RSW'(2) <= size_r) &&
                      (cc >= CSW'(1)) && (cc + CSW'(2) <= size_c);
    assign hex_a    = (!r_row[0] && r_col[1:0] == 2'd0) || (r_row[0] && r_col[1:0] == 2'd2);
    assign hex_b    = (r_row[0] && r_col[1:0] == 2'd1) || (!r_row[0] && r_col[1:0] == 2'd3);

    always_comb begin
        topple_mask = '0;
        topple_ok   = 1'b0;
        unique case (r_lattice)
            LAT_SQUARE: begin
                topple_ok = 1'b1;
                topple_mask[SLOT_UP]       = !top;
                topple_mask[SLOT_DOWN]     = !bot;
                topple_mask[SLOT_LEFT]     = !lef;
                topple_mask[SLOT_RIGHT]    = !rig;
                topple_mask[SLOT_WRAP_ROW] = r_wrap_rows && (top || bot) && !corner;
                topple_mask[SLOT_WRAP_COL] = r_wrap_cols && (lef || rig) && !corner;
            end
            LAT_TRIANGLE: begin
                topple_ok = interior;
                topple_mask[SLOT_UP_LEFT]  = 1'b1;
                topple_mask[SLOT_UP_RIGHT] = 1'b1;
                topple_mask[SLOT_DN_LEFT]  = 1'b1;
                topple_mask[SLOT_DN_RIGHT] = 1'b1;
                topple_mask[SLOT_LEFT2]    = (cc >= CSW'(2));
                topple_mask[SLOT_RIGHT2]   = (cc + CSW'(2) < size_c);
            end
            LAT_HEXAGON: begin
                topple_ok = interior && (hex_a || hex_b);
                topple_mask[SLOT_LEFT]     = hex_a;
                topple_mask[SLOT_UP_RIGHT] = hex_a;
                topple_mask[SLOT_DN_RIGHT] = hex_a;
                topple_mask[SLOT_RIGHT]    = hex_b;
                topple_mask[SLOT_UP_LEFT]  = hex_b;
                topple_mask[SLOT_DN_LEFT]  = hex_b;
            end
            default: ;
        endcase
    end

    // next neighbour: lowest pending slot
    logic [SLOT_BITS-1:0] slot_sel;
    logic [RSW-1:0]       nb_r;
    logic [CSW-1:0]       nb_c;
    logic [AW-1:0]        slot_addr;

    always_comb begin
        slot_sel = '0;
        for (int k = NUM_SLOTS - 1; k >= 0; k--) begin
            if (r_mask[k]) begin
                slot_sel = SLOT_BITS'(k);
            end
        end
    end

    always_comb begin
        nb_r = rr;
        nb_c = cc;
        case (slot_sel)
            SLOT_UP:       nb_r = rr - RSW'(1);
            SLOT_DOWN:     nb_r = rr + RSW'(1);
            SLOT_LEFT:     nb_c = cc - CSW'(1);
            SLOT_RIGHT:    nb_c = cc + CSW'(1);
            SLOT_UP_LEFT:  begin nb_r = rr - RSW'(1); nb_c = cc - CSW'(1); end
            SLOT_UP_RIGHT: begin nb_r = rr - RSW'(1); nb_c = cc + CSW'(1); end
            SLOT_DN_LEFT:  begin nb_r = rr + RSW'(1); nb_c = cc - CSW'(1); end
            SLOT_DN_RIGHT: begin nb_r = rr + RSW'(1); nb_c = cc + CSW'(1); end
            SLOT_LEFT2:    nb_c = cc - CSW'(2);
            SLOT_RIGHT2:   nb_c = cc + CSW'(2);
            SLOT_WRAP_ROW: begin
                nb_r = top ? (size_r - RSW'(1)) : '0;
                nb_c = size_c - cc;
            end
            SLOT_WRAP_COL: begin
                nb_r = size_r - rr;
                nb_c = lef ? (size_c - CSW'(1)) : '0;
            end
            default: ;
        endcase
    end

    assign slot_addr = {nb_r[RB-1:0], nb_c[CB-1:0]};

    // shared divider step: DIV_DIGITS bits per cycle
    logic [REM_BITS-1:0]   step_rem;
    logic [REM_BITS:0]     step_res;
    logic [DIV_DIGITS-1:0] step_q;
    logic [DIV_BITS-1:0]   n_dvd;
    logic                  div_last;

    always_comb begin
        step_rem = r_rem;
        step_q   = '0;
        step_res = '0;
        for (int k = 0; k < DIV_DIGITS; k++) begin
            step_res = div_step(step_rem, r_dvd[DIV_BITS-1-k], r_dsr);
            step_q[DIV_DIGITS-1-k] = step_res[REM_BITS];
            step_rem = step_res[REM_BITS-1:0];
        end
        n_dvd = {r_dvd[DIV_BITS-DIV_DIGITS-1:0], step_q};
    end

    assign div_last = (r_cnt == DIV_CNT_BITS'(DIV_ITERS - 1));

    // grid memory and shared saturating adder
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [CELL_BITS-1:0] ram_wdata;
    logic                 ram_re;
    logic [AW-1:0]        ram_raddr;
    logic [CELL_BITS-1:0] ram_rdata;
    logic [TOTAL_BITS-1:0] cell_total;
    logic [CELL_BITS-1:0]  sat_sum;

    assign cell_total = TOTAL_BITS'(ram_rdata) + TOTAL_BITS'(r_addend);
    assign sat_sum    = (cell_total > TOTAL_BITS'(CELL_MAX)) ? CELL_MAX :
                                                               cell_total[CELL_BITS-1:0];

    stp_ram #(
        .WIDTH (CELL_BITS),
        .DEPTH (DEPTH)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = tgt_addr;
        ram_wdata = sat_sum;
        ram_re    = 1'b0;
        ram_raddr = in_addr;
        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
                ram_wdata = CELL_BITS'(CELL_RESET);
            end
            S_IDLE: begin
                ram_re = req_fire && in_range;
            end
            S_TGT: begin
                ram_we = (r_op == OP_ADD);
            end
            S_DIV: begin
                ram_we    = div_last;
                ram_wdata = CELL_BITS'(step_rem);
            end
            S_GIVE: begin
                ram_we    = r_pend;
                ram_waddr = r_paddr;
                ram_re    = |r_mask;
                ram_raddr = slot_addr;
            end
            S_DONE: ;
            default: ;
        endcase
    end

    logic out_free;
    assign out_free = !r_ovalid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_mask     <= '0;
            r_pend     <= 1'b0;
            r_cnt      <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            if (r_state == S_DONE && out_free) begin
                r_ovalid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (r_clr_addr == {AW{1'b1}}) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (req_fire) begin
                        r_op     <= i_req.op;
                        r_row    <= i_req.row;
                        r_col    <= i_req.col;
                        r_addend <= i_req.grains;
                        if (in_range) begin
                            r_state <= S_TGT;
                        end else begin
                            r_res_cell    <= '0;
                            r_res_share   <= '0;
                            r_res_applied <= 1'b0;
                            r_state       <= S_DONE;
                        end
                    end
                end
                S_TGT: begin
                    if (r_op == OP_ADD) begin
                        r_res_cell    <= DATA_BITS'(sat_sum);
                        r_res_share   <= '0;
                        r_res_applied <= 1'b1;
                        r_state       <= S_DONE;
                    end else if (topple_ok) begin
                        r_dvd   <= DIV_BITS'(cell_total);
                        r_rem   <= '0;
                        r_dsr   <= divisor_of(r_lattice);
                        r_cnt   <= '0;
                        r_mask  <= topple_mask;
                        r_state <= S_DIV;
                    end else begin
                        r_res_cell    <= DATA_BITS'(ram_rdata);
                        r_res_share   <= '0;
                        r_res_applied <= 1'b0;
                        r_state       <= S_DONE;
                    end
                end
                S_DIV: begin
                    r_dvd <= n_dvd;
                    r_rem <= step_rem;
                    r_cnt <= r_cnt + DIV_CNT_BITS'(1);
                    if (div_last) begin
                        r_addend      <= n_dvd[DATA_BITS-1:0];
                        r_res_share   <= n_dvd[DATA_BITS-1:0];
                        r_res_cell    <= DATA_BITS'(step_rem);
                        r_res_applied <= 1'b1;
                        r_pend        <= 1'b0;
                        r_state       <= S_GIVE;
                    end
                end
                S_GIVE: begin
                    if (|r_mask) begin
                        r_mask[slot_sel] <= 1'b0;
                        r_paddr          <= slot_addr;
                        r_pend           <= 1'b1;
                    end else begin
                        r_pend  <= 1'b0;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_ocell    <= r_res_cell;
                        r_oshare   <= r_res_share;
                        r_oapplied <= r_res_applied;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.valid      = r_ovalid;
    assign o_rsp.cell_value = r_ocell;
    assign o_rsp.share      = r_oshare;
    assign o_rsp.applied    = r_oapplied;

    a_accept_moves_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_fire |=> (r_state == S_TGT || r_state == S_DONE))
        else $error("accepted word did not start its sequence");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_DONE) |-> !ram_we)
        else $error("grid written while no word in progress");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_dsr))
        else $error("divider remainder out of range");

    a_ignored_no_share: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.applied) |-> (o_rsp.share == '0))
        else $error("ignored word carries a share");

endmodule
